// ----- hdl/wli_pkg.sv -----
`default_nettype none

package wli_pkg;

    // coordinate and difference widths (signed Q16.16)
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CFG_W   = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_X,
        S_DIV_Y,
        S_EMIT,
        S_END
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/waypoint_linear_interpolator.sv -----
`default_nettype none
// first output: the first waypoint is offered once a reference word is taken and both
//   per-axis step divisions are done; they share one bit-serial divider, x then y
// flow: a reference with a stored point holds off the next accept until its divisions
//   and waypoints are done, and the path end point too at end of path; a first point
//   needs no division and, if it also ends the path, goes out alone; waypoints leave at one per cycle unless stalled
// reset: synchronous active low, clears points_between, stored point and sequencer

module waypoint_linear_interpolator #(
    parameter int MAX_POINTS_BETWEEN = 30
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration: points_between
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [wli_pkg::CFG_W-1:0]      i_cfg_data,
    // reference points
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [2*wli_pkg::COORD_W-1:0]  s_axis_tdata,  // ref_x, ref_y
    input  wire                            s_axis_tlast,  // end_of_path
    // waypoints
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [2*wli_pkg::COORD_W-1:0]  m_axis_tdata,  // point_x, point_y
    output logic                           m_axis_tlast   // last_of_run
);
    import wli_pkg::*;

    // counter and divisor width: divisor is at most MAX_POINTS_BETWEEN + 1
    localparam int CNT_W = $clog2(MAX_POINTS_BETWEEN + 2);
    localparam int SAT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]          r_points_between;
    logic                      r_have_prev;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_W-1:0] r_cur_x, r_cur_y;
    logic                      r_eop;
    logic signed [DIFF_W-1:0]  r_step_x, r_step_y;
    logic signed [COORD_W-1:0] r_acc_x, r_acc_y;
    logic [CNT_W-1:0]          r_cnt;

    logic                      s_acc, m_acc, cnt_end;
    logic [CNT_W-1:0]          pb_eff;
    logic [CNT_W-1:0]          divisor;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic signed [DIFF_W-1:0]  diff_in_x, diff_y, dividend;
    logic                      div_start, div_done;
    logic signed [DIFF_W-1:0]  quotient;

    assign in_x  = s_axis_tdata[COORD_W-1:0];
    assign in_y  = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // register value saturated at the parameter
    assign pb_eff  = (SAT_W'(r_points_between) > SAT_W'(MAX_POINTS_BETWEEN))
                   ? CNT_W'(MAX_POINTS_BETWEEN) : CNT_W'(r_points_between);
    assign divisor = pb_eff + 1'b1;
    assign cnt_end = (r_cnt == pb_eff);

    // exact 33-bit differences; x comes straight from the incoming word
    assign diff_in_x = {in_x[COORD_W-1], in_x} - {r_prev_x[COORD_W-1], r_prev_x};
    assign diff_y    = {r_cur_y[COORD_W-1], r_cur_y} - {r_prev_y[COORD_W-1], r_prev_y};
    assign dividend  = (r_state == S_IDLE) ? diff_in_x : diff_y;

    // shared step divider, x first then y
    wli_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_between <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_points_between <= i_cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (r_have_prev) begin
                        n_state = S_DIV_X;
                    end else if (s_axis_tlast) begin
                        n_state = S_END;
                    end
                end
            end
            S_DIV_X: begin
                if (div_done) begin
                    n_state = S_DIV_Y;
                end
            end
            S_DIV_Y: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_acc && cnt_end) begin
                    n_state = r_eop ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (m_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tlast  = 1'b0;
        div_start     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                div_start     = s_axis_tvalid && r_have_prev;
            end
            S_DIV_X: begin
                div_start = div_done;
            end
            S_DIV_Y: begin
            end
            S_EMIT: begin
                m_axis_tvalid = 1'b1;
                // segment end closes the run unless the path end point follows
                m_axis_tlast  = !r_eop && cnt_end;
            end
            S_END: begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = {r_acc_y, r_acc_x};

    // datapath: stored point, steps and the running waypoint
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_cnt       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_cur_x <= in_x;
                        r_cur_y <= in_y;
                        r_eop   <= s_axis_tlast;
                        if (!r_have_prev) begin
                            if (s_axis_tlast) begin
                                // lone path point goes straight out
                                r_acc_x <= in_x;
                                r_acc_y <= in_y;
                            end else begin
                                r_prev_x    <= in_x;
                                r_prev_y    <= in_y;
                                r_have_prev <= 1'b1;
                            end
                        end
                    end
                end
                S_DIV_X: begin
                    if (div_done) begin
                        r_step_x <= quotient;
                    end
                end
                S_DIV_Y: begin
                    if (div_done) begin
                        r_step_y <= quotient;
                        r_acc_x  <= r_prev_x;
                        r_acc_y  <= r_prev_y;
                        r_cnt    <= '0;
                    end
                end
                S_EMIT: begin
                    if (m_acc) begin
                        if (cnt_end) begin
                            if (r_eop) begin
                                r_acc_x <= r_cur_x;
                                r_acc_y <= r_cur_y;
                            end else begin
                                r_prev_x    <= r_cur_x;
                                r_prev_y    <= r_cur_y;
                                r_have_prev <= 1'b1;
                            end
                        end else begin
                            // previous + i*step built by repeated addition
                            r_acc_x <= r_acc_x + r_step_x[COORD_W-1:0];
                            r_acc_y <= r_acc_y + r_step_y[COORD_W-1:0];
                            r_cnt   <= r_cnt + 1'b1;
                        end
                    end
                end
                S_END: begin
                    if (m_acc) begin
                        r_have_prev <= 1'b0;
                        r_prev_x    <= '0;
                        r_prev_y    <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/wli_div.sv -----
`default_nettype none

module wli_div #(
    parameter int DIVISOR_W = 5
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    input  wire  signed [wli_pkg::DIFF_W-1:0]    i_dividend,
    input  wire         [DIVISOR_W-1:0]          i_divisor,
    output logic                                 o_done,
    output logic signed [wli_pkg::DIFF_W-1:0]    o_quotient
);
    import wli_pkg::*;

    localparam int STEP_W = $clog2(DIFF_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic                 r_neg;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIFF_W-1:0]    r_quo;

    logic [DIFF_W-1:0]    mag;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   trial_sub;
    logic                 ge;
    logic [DIVISOR_W-1:0] n_rem;

    // magnitude of the dividend, quotient truncates toward zero
    assign mag       = i_dividend[DIFF_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign trial     = {r_rem, r_quo[DIFF_W-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign ge        = (trial >= {1'b0, r_div});
    assign n_rem     = ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[DIFF_W-1];
                r_quo  <= mag;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIFF_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(~r_quo + 1'b1) : $signed(r_quo);

endmodule

`default_nettype wire
